FILE: hdl/cba_pkg.sv
`default_nettype none
package cba_pkg;
   localparam int MaxBlocks = 1024;
   localparam int GroupSize = 128;
   localparam int NumGroups = (MaxBlocks + GroupSize - 1) / GroupSize;
   localparam int BlkW = 10;
   localparam int GrpW = 3;
   localparam int OffW = 7;
   localparam int CntW = 11;
   localparam logic [7:0] HintUnknown = 8'd255;

   localparam logic [1:0] OpAlloc = 2'd0;
   localparam logic [1:0] OpFree = 2'd1;
   localparam logic [1:0] OpNext = 2'd2;
   localparam logic [1:0] OpUnused = 2'd3;

   typedef struct packed {
      logic [1:0] op;
      logic [BlkW-1:0] block;
      logic has_block;
      logic grow;
   } req_type;

   typedef struct packed {
      logic [BlkW-1:0] result_block;
      logic is_none;
      logic [CntW-1:0] free_total;
   } rsp_type;

   // link entry: bit 10 set is the free marker
   typedef logic [BlkW:0] link_type;
endpackage
`default_nettype wire

FILE: hdl/cba_link_ram.sv
`default_nettype none
module cba_link_ram (
   input  wire logic clock,
   input  wire logic we,
   input  wire logic [cba_pkg::BlkW-1:0] waddr,
   input  wire cba_pkg::link_type wdata,
   input  wire logic [cba_pkg::BlkW-1:0] raddr,
   output cba_pkg::link_type rdata
);
   cba_pkg::link_type mem [cba_pkg::MaxBlocks];
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

FILE: hdl/chained_block_allocator_core.sv
// chained block allocator: a link table of 1024 entries, one per block, in groups of 128
// req channel: valid/ready, one transfer is one request (allocate, free chain, next link)
// rsp channel: valid/ready, exactly one response transfer per request
// csr port: csr_we writes block_count; tables are reinitialised by a clearing pass
// rate: sequential, one request at a time; link memory one read and one write per cycle
// allocate: groups are searched in order and empty groups skipped; a good group hint is
// checked first, else the group is scanned block by block; when linking, the link is written last
// free: the chain is walked block by block, each block read and then marked free
// next: the link entry is read and returned, plus an allocation when it grows the chain
// after reset or a csr write a clearing pass marks all 1024 entries free,
// during which req_ready is low
// response is held in an output register; while rsp_ready is low the block waits
// with the result and takes no new request until the response transfer
`default_nettype none
module chained_block_allocator_core (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire cba_pkg::req_type req_data,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output cba_pkg::rsp_type rsp_data,
   input  wire logic csr_we,
   input  wire logic [cba_pkg::CntW-1:0] csr_data
);
   localparam logic [3:0] StClear = 4'd0, StIdle = 4'd1, StRd = 4'd2, StOp = 4'd3,
      StAGrp = 4'd4, StAHint = 4'd5, StAScan = 4'd6, StAChk = 4'd7,
      StFree = 4'd8, StFreeChk = 4'd9, StRsp = 4'd10, StAHintChk = 4'd11;

   logic [3:0] state_ff, state_in;
   logic [cba_pkg::CntW-1:0] bc_ff, bc_in, free_ff, free_in;
   logic [cba_pkg::BlkW-1:0] clr_ff, clr_in;
   cba_pkg::req_type req_ff, req_in;
   logic [7:0] gcnt_ff [cba_pkg::NumGroups];
   logic [7:0] gcnt_in [cba_pkg::NumGroups];
   logic [7:0] ghint_ff [cba_pkg::NumGroups];
   logic [7:0] ghint_in [cba_pkg::NumGroups];
   logic [cba_pkg::GrpW-1:0] grp_ff, grp_in;
   logic [cba_pkg::OffW:0] off_ff, off_in;
   logic [cba_pkg::BlkW-1:0] cur_ff, cur_in;
   logic dolink_ff, dolink_in;
   cba_pkg::rsp_type rsp_ff, rsp_in;

   logic we;
   logic [cba_pkg::BlkW-1:0] waddr, raddr;
   cba_pkg::link_type wdata, rdata;

   cba_link_ram u_ram (.clock(clock), .we(we), .waddr(waddr), .wdata(wdata),
      .raddr(raddr), .rdata(rdata));

   logic [cba_pkg::CntW-1:0] bcsat;
   logic present;
   logic [cba_pkg::CntW-1:0] base, cand;
   logic [cba_pkg::BlkW-1:0] curg_blk;

   assign bcsat = (csr_data > cba_pkg::CntW'(cba_pkg::MaxBlocks))
      ? cba_pkg::CntW'(cba_pkg::MaxBlocks) : csr_data;
   assign present = req_ff.has_block && ({1'b0, req_ff.block} < bc_ff);
   assign base = {1'b0, grp_ff, {cba_pkg::OffW{1'b0}}};
   assign cand = base + cba_pkg::CntW'(off_ff);
   assign curg_blk = cand[cba_pkg::BlkW-1:0];

   assign req_ready = (state_ff == StIdle);
   assign rsp_valid = (state_ff == StRsp);
   assign rsp_data = rsp_ff;

   always_comb begin
      logic [cba_pkg::CntW-1:0] n;
      state_in = state_ff; bc_in = bc_ff; free_in = free_ff; clr_in = clr_ff;
      req_in = req_ff; grp_in = grp_ff; off_in = off_ff; cur_in = cur_ff;
      dolink_in = dolink_ff; rsp_in = rsp_ff;
      gcnt_in = gcnt_ff; ghint_in = ghint_ff;
      we = 1'b0; waddr = cur_ff; wdata = '0; raddr = cur_ff;
      n = '0;
      case (state_ff)
         StClear: begin
            we = 1'b1; waddr = clr_ff;
            wdata = {1'b1, {cba_pkg::BlkW{1'b0}}};
            clr_in = clr_ff + 1'b1;
            if (clr_ff == cba_pkg::BlkW'(cba_pkg::MaxBlocks - 1)) state_in = StIdle;
         end
         StIdle: begin
            if (req_valid) begin
               req_in = req_data; state_in = StRd;
            end
         end
         StRd: begin
            raddr = req_ff.block; cur_in = req_ff.block;
            rsp_in.result_block = '0; rsp_in.is_none = 1'b1;
            state_in = StOp;
            if (req_ff.op == cba_pkg::OpFree) state_in = present ? StFreeChk : StRsp;
            if (req_ff.op == cba_pkg::OpUnused) state_in = StRsp;
         end
         StOp: begin
            grp_in = '0;
            if (req_ff.op == cba_pkg::OpAlloc) begin
               dolink_in = present && !rdata[cba_pkg::BlkW];
               state_in = StAGrp;
            end else if (!present) begin
               state_in = StRsp;
            end else if ((rdata[cba_pkg::BlkW] || rdata == '0) && req_ff.grow) begin
               dolink_in = !rdata[cba_pkg::BlkW];
               state_in = StAGrp;
            end else begin
               rsp_in.result_block = rdata[cba_pkg::BlkW-1:0];
               rsp_in.is_none = rdata[cba_pkg::BlkW];
               state_in = StRsp;
            end
         end
         StAGrp: begin
            if (gcnt_ff[grp_ff] == '0) begin
               if (grp_ff == cba_pkg::GrpW'(cba_pkg::NumGroups - 1)) state_in = StRsp;
               else grp_in = grp_ff + 1'b1;
            end else begin
               off_in = ghint_ff[grp_ff][cba_pkg::OffW:0];
               if (ghint_ff[grp_ff] != cba_pkg::HintUnknown
                   && ghint_ff[grp_ff] < 8'(cba_pkg::GroupSize)
                   && (base + cba_pkg::CntW'(ghint_ff[grp_ff])) < bc_ff)
                  state_in = StAHint;
               else begin
                  off_in = '0; state_in = StAScan;
               end
            end
         end
         StAHint: begin
            raddr = curg_blk; state_in = StAHintChk;
         end
         StAHintChk: begin
            raddr = curg_blk;
            if (rdata[cba_pkg::BlkW]) state_in = StAChk;
            else begin
               off_in = '0; state_in = StAScan;
            end
         end
         StAScan: begin
            if (off_ff == (cba_pkg::OffW+1)'(cba_pkg::GroupSize) || cand >= bc_ff) begin
               gcnt_in[grp_ff] = '0;
               if (grp_ff == cba_pkg::GrpW'(cba_pkg::NumGroups - 1)) state_in = StRsp;
               else begin
                  grp_in = grp_ff + 1'b1; state_in = StAGrp;
               end
            end else begin
               raddr = curg_blk;
               state_in = StAChk;
            end
         end
         StAChk: begin
            if (rdata[cba_pkg::BlkW]) begin
               we = 1'b1; waddr = curg_blk; wdata = '0;
               ghint_in[grp_ff] = cba_pkg::HintUnknown;
               gcnt_in[grp_ff] = gcnt_ff[grp_ff] - 1'b1;
               if (free_ff != '0) free_in = free_ff - 1'b1;
               rsp_in.result_block = curg_blk; rsp_in.is_none = 1'b0;
               cur_in = curg_blk;
               state_in = dolink_ff ? StFree : StRsp;
            end else begin
               off_in = off_ff + 1'b1; state_in = StAScan;
            end
         end
         StFree: begin
            // link previous block to the new one
            we = 1'b1; waddr = req_ff.block; wdata = {1'b0, cur_ff};
            state_in = StRsp;
         end
         StFreeChk: begin
            rsp_in.is_none = 1'b0;
            if (({1'b0, cur_ff} >= bc_ff) || rdata[cba_pkg::BlkW]) state_in = StRsp;
            else begin
               we = 1'b1; waddr = cur_ff; wdata = {1'b1, {cba_pkg::BlkW{1'b0}}};
               gcnt_in[cur_ff[cba_pkg::BlkW-1 -: cba_pkg::GrpW]] =
                  gcnt_ff[cur_ff[cba_pkg::BlkW-1 -: cba_pkg::GrpW]] + 1'b1;
               ghint_in[cur_ff[cba_pkg::BlkW-1 -: cba_pkg::GrpW]] =
                  8'(cur_ff[cba_pkg::OffW-1:0]);
               free_in = free_ff + 1'b1;
               if (rdata == '0) state_in = StRsp;
               else begin
                  cur_in = rdata[cba_pkg::BlkW-1:0];
                  state_in = StRd;
                  req_in.block = rdata[cba_pkg::BlkW-1:0];
                  req_in.has_block = 1'b1;
                  req_in.op = cba_pkg::OpFree;
               end
            end
         end
         StRsp: begin
            if (rsp_ready) state_in = StIdle;
         end
         default: state_in = StIdle;
      endcase
      if (state_ff == StRd && req_ff.op == cba_pkg::OpFree && present)
         rsp_in.is_none = 1'b0;
      if (state_in == StRsp) rsp_in.free_total = free_in;
      if (csr_we) begin
         bc_in = bcsat; free_in = bcsat; clr_in = '0; state_in = StClear;
         for (int g = 0; g < cba_pkg::NumGroups; g++) begin
            n = (bcsat > cba_pkg::CntW'(g * cba_pkg::GroupSize))
               ? bcsat - cba_pkg::CntW'(g * cba_pkg::GroupSize) : '0;
            gcnt_in[g] = (n > cba_pkg::CntW'(cba_pkg::GroupSize))
               ? 8'(cba_pkg::GroupSize) : n[7:0];
            ghint_in[g] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StClear; clr_ff <= '0;
         bc_ff <= cba_pkg::CntW'(cba_pkg::MaxBlocks);
         free_ff <= cba_pkg::CntW'(cba_pkg::MaxBlocks);
         for (int g = 0; g < cba_pkg::NumGroups; g++) begin
            gcnt_ff[g] <= 8'(cba_pkg::GroupSize); ghint_ff[g] <= '0;
         end
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; bc_ff <= bc_in; free_ff <= free_in;
         gcnt_ff <= gcnt_in; ghint_ff <= ghint_in;
      end
      req_ff <= req_in; grp_ff <= grp_in; off_ff <= off_in; cur_ff <= cur_in;
      dolink_ff <= dolink_in; rsp_ff <= rsp_in;
   end
endmodule
`default_nettype wire

FILE: bench/chained_block_allocator_core_test.sv
`timescale 1ns / 100ps
module chained_block_allocator_core_test;
   localparam int NoBlock = -1;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   cba_pkg::req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   cba_pkg::rsp_type rsp_data;
   logic csr_we;
   logic [cba_pkg::CntW-1:0] csr_data;

   chained_block_allocator_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_data(csr_data)
   );

   // allocator state as seen from outside
   cba_pkg::link_type chain_link [cba_pkg::MaxBlocks];
   int group_count [cba_pkg::NumGroups];
   int group_hint [cba_pkg::NumGroups];
   int usable_blocks;
   int blocks_free;

   cba_pkg::rsp_type pending_rsp [$];
   int fail_count = 0;
   int burst_left = 0;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      #200_000_000;
      $display("[chained_block_allocator_core] ERROR");
      $finish;
   end

   function automatic void clear_tables(int count);
      int n;
      if (count > cba_pkg::MaxBlocks) count = cba_pkg::MaxBlocks;
      usable_blocks = count;
      for (int i = 0; i < cba_pkg::MaxBlocks; i++)
         chain_link[i] = {1'b1, {cba_pkg::BlkW{1'b0}}};
      for (int g = 0; g < cba_pkg::NumGroups; g++) begin
         n = count - g * cba_pkg::GroupSize;
         if (n < 0) n = 0;
         if (n > cba_pkg::GroupSize) n = cba_pkg::GroupSize;
         group_count[g] = n;
         group_hint[g] = 0;
      end
      blocks_free = count;
   endfunction

   function automatic bit is_free(int b);
      return chain_link[b][cba_pkg::BlkW];
   endfunction

   function automatic int take_block(int prev, bit do_link);
      int base;
      int h;
      int blk;
      for (int g = 0; g < cba_pkg::NumGroups; g++) begin
         base = g * cba_pkg::GroupSize;
         h = group_hint[g];
         blk = NoBlock;
         if (group_count[g] == 0) continue;
         if (h != int'(cba_pkg::HintUnknown) && h < cba_pkg::GroupSize
             && base + h < usable_blocks && is_free(base + h)) begin
            blk = base + h;
         end else begin
            for (int i = 0; i < cba_pkg::GroupSize && base + i < usable_blocks; i++) begin
               if (is_free(base + i)) begin
                  blk = base + i;
                  break;
               end
            end
         end
         if (blk == NoBlock) begin
            group_count[g] = 0;
            continue;
         end
         group_hint[g] = int'(cba_pkg::HintUnknown);
         group_count[g]--;
         chain_link[blk] = '0;
         if (do_link) chain_link[prev] = cba_pkg::link_type'(blk);
         if (blocks_free > 0) blocks_free--;
         return blk;
      end
      return NoBlock;
   endfunction

   function automatic void release_chain(int cur);
      cba_pkg::link_type nxt;
      while (cur < usable_blocks && !is_free(cur)) begin
         nxt = chain_link[cur];
         chain_link[cur] = {1'b1, {cba_pkg::BlkW{1'b0}}};
         group_count[cur / cba_pkg::GroupSize]++;
         group_hint[cur / cba_pkg::GroupSize] = cur % cba_pkg::GroupSize;
         blocks_free++;
         if (nxt == 0) break;
         cur = int'(nxt);
      end
   endfunction

   function automatic cba_pkg::rsp_type predict_rsp(cba_pkg::req_type r);
      cba_pkg::rsp_type o;
      int res;
      int b;
      bit present;
      cba_pkg::link_type nxt;
      b = int'(r.block);
      present = r.has_block && b < usable_blocks;
      res = NoBlock;
      case (r.op)
         cba_pkg::OpAlloc: res = take_block(b, present && !is_free(b));
         cba_pkg::OpFree: begin
            if (present) begin
               release_chain(b);
               res = 0;
            end
         end
         cba_pkg::OpNext: begin
            if (present) begin
               nxt = chain_link[b];
               if ((nxt == 0 || nxt[cba_pkg::BlkW]) && r.grow)
                  res = take_block(b, !nxt[cba_pkg::BlkW]);
               else if (!nxt[cba_pkg::BlkW]) res = int'(nxt);
            end
         end
         default: res = NoBlock;
      endcase
      o.result_block = (res == NoBlock) ? '0 : res[cba_pkg::BlkW-1:0];
      o.is_none = (res == NoBlock);
      o.free_total = blocks_free[cba_pkg::CntW-1:0];
      return o;
   endfunction

   always @(posedge clock) begin
      cba_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("response transfer with nothing expected: %p", rsp_data);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.result_block !== want.result_block) begin
               $error("result_block expected %0d actual %0d", want.result_block,
                      rsp_data.result_block);
               fail_count++;
            end
            if (rsp_data.is_none !== want.is_none) begin
               $error("is_none expected %0d actual %0d", want.is_none, rsp_data.is_none);
               fail_count++;
            end
            if (rsp_data.free_total !== want.free_total) begin
               $error("free_total expected %0d actual %0d", want.free_total,
                      rsp_data.free_total);
               fail_count++;
            end
         end
      end
   end

   // receiver stall pattern: switches at random between four modes of rsp_ready
   initial begin
      int mode;
      rsp_ready = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(50, 300)) begin
            @(negedge clock);
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ~rsp_ready;
            endcase
         end
      end
   end

   task automatic send_req(cba_pkg::req_type r);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      pending_rsp.push_back(predict_rsp(r));
      burst_left--;
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   task automatic write_block_count(int value);
      drain();
      repeat (8) @(negedge clock);
      csr_we <= 1'b1;
      csr_data <= value[cba_pkg::CntW-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
      clear_tables(value);
   endtask

   function automatic cba_pkg::req_type make_req(logic [1:0] op, int b, bit has, bit grow);
      cba_pkg::req_type r;
      r.op = op;
      r.block = b[cba_pkg::BlkW-1:0];
      r.has_block = has;
      r.grow = grow;
      return r;
   endfunction

   function automatic int pick_used_block();
      int start;
      int b;
      start = $urandom_range(0, cba_pkg::MaxBlocks - 1);
      for (int i = 0; i < cba_pkg::MaxBlocks; i++) begin
         b = (start + i) % cba_pkg::MaxBlocks;
         if (b < usable_blocks && !is_free(b)) return b;
      end
      return $urandom_range(0, cba_pkg::MaxBlocks - 1);
   endfunction

   task automatic test_basic_ops;
      write_block_count(1024);
      send_req(make_req(cba_pkg::OpAlloc, 0, 0, 0));
      send_req(make_req(cba_pkg::OpAlloc, 0, 1, 0));
      send_req(make_req(cba_pkg::OpNext, 0, 1, 0));
      send_req(make_req(cba_pkg::OpNext, 1, 1, 1));
      send_req(make_req(cba_pkg::OpNext, 1023, 1, 0));
      send_req(make_req(cba_pkg::OpNext, 1023, 1, 1));
      send_req(make_req(cba_pkg::OpAlloc, 500, 1, 0));
      send_req(make_req(cba_pkg::OpNext, 7, 0, 1));
      send_req(make_req(cba_pkg::OpFree, 0, 1, 0));
      send_req(make_req(cba_pkg::OpFree, 0, 1, 0));
      send_req(make_req(cba_pkg::OpFree, 3, 0, 0));
      send_req(make_req(cba_pkg::OpUnused, 1023, 1, 1));
      send_req(make_req(cba_pkg::OpAlloc, 0, 0, 0));
   endtask

   task automatic test_tiny_disk;
      write_block_count(1);
      send_req(make_req(cba_pkg::OpAlloc, 0, 0, 0));
      send_req(make_req(cba_pkg::OpAlloc, 0, 1, 0));
      send_req(make_req(cba_pkg::OpNext, 0, 1, 1));
      send_req(make_req(cba_pkg::OpNext, 1, 1, 1));
      send_req(make_req(cba_pkg::OpFree, 0, 1, 0));
      write_block_count(0);
      send_req(make_req(cba_pkg::OpAlloc, 0, 0, 0));
      send_req(make_req(cba_pkg::OpNext, 0, 1, 1));
      send_req(make_req(cba_pkg::OpFree, 0, 1, 0));
   endtask

   task automatic test_random_chains(int count, int items);
      cba_pkg::req_type r;
      int sel;
      write_block_count(count);
      for (int n = 0; n < items; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < 8) begin
            r = cba_pkg::req_type'($bits(cba_pkg::req_type)'($urandom));
         end else begin
            r.block = (sel < 80) ? cba_pkg::BlkW'(pick_used_block())
               : cba_pkg::BlkW'($urandom_range(0, cba_pkg::MaxBlocks - 1));
            r.has_block = ($urandom_range(0, 9) != 0);
            r.grow = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
               0, 1, 2, 3: r.op = cba_pkg::OpAlloc;
               4, 5: r.op = cba_pkg::OpFree;
               default: r.op = cba_pkg::OpNext;
            endcase
         end
         send_req(r);
         if (n == items / 2) drain();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_data = '0;
      clear_tables(cba_pkg::MaxBlocks);
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_req(make_req(cba_pkg::OpAlloc, 0, 0, 0));
      test_basic_ops();
      test_tiny_disk();
      test_random_chains(5, 250);
      test_random_chains(130, 350);
      test_random_chains(2047, 350);
      test_random_chains(1024, 350);
      test_random_chains($urandom_range(1, 1024), 350);
      drain();
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("[chained_block_allocator_core] OK");
      end else begin
         $display("[chained_block_allocator_core] ERROR");
      end
      $finish;
   end
endmodule
